FILE: rtl/hcp_pkg.sv
// hcp_pkg: types, constants and helpers of the height/colour token parser
// used by every module under rtl; depends on nothing else
package hcp_pkg;

	// queue between the classifier and the parser
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = QPtrW + 1;

	// character codes
	localparam logic [7:0] CharNul     = 8'h00;
	localparam logic [7:0] CharNewline = 8'h0A;
	localparam logic [7:0] CharTab     = 8'h09;
	localparam logic [7:0] CharCr      = 8'h0D;
	localparam logic [7:0] CharSpace   = 8'h20;
	localparam logic [7:0] CharPlus    = 8'h2B;
	localparam logic [7:0] CharMinus   = 8'h2D;
	localparam logic [7:0] CharZero    = 8'h30;
	localparam logic [7:0] CharNine    = 8'h39;
	localparam logic [7:0] CharUpperA  = 8'h41;
	localparam logic [7:0] CharUpperF  = 8'h46;
	localparam logic [7:0] CharLowerX  = 8'h78;

	// numeric limits
	localparam logic [31:0] MagLimit  = 32'h8000_0000;
	localparam logic [31:0] HeightMax = 32'h7FFF_FFFF;
	localparam logic [2:0]  HexNeeded = 3'd6;

	// register reset values
	localparam logic [31:0] DefaultColorReset = 32'h00FF_FFFF;
	localparam logic [7:0]  SeparatorReset    = 8'd44;

	// register indexes
	typedef enum logic {
		CFG_DEFAULT_COLOR = 1'b0,
		CFG_SEPARATOR     = 1'b1
	} cfg_index_t;

	// parser phase
	typedef enum logic [2:0] {
		PH_BETWEEN,
		PH_DIGITS,
		PH_ZERO,
		PH_X,
		PH_HEX,
		PH_SKIP
	} phase_t;

	// classified byte passed from front to back
	typedef struct packed {
		logic       line_end;
		logic       space;
		logic       digit;
		logic [3:0] dval;
		logic       sign;
		logic       minus;
		logic       sep;
		logic       zero_ch;
		logic       x_ch;
		logic       hex_ok;
		logic [3:0] hval;
	} char_class_t;

	// one result item
	typedef struct packed {
		logic        point_present;
		logic [31:0] height;
		logic [31:0] color;
		logic        error_flag;
		logic        line_done;
	} result_t;

	// sort one byte into the classes the parser tests
	function automatic char_class_t classify(input logic [7:0] c, input logic [7:0] sep);
		char_class_t k;
		k.line_end = (c == CharNul) || (c == CharNewline);
		k.space    = (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
		k.digit    = (c >= CharZero) && (c <= CharNine);
		k.dval     = c[3:0];
		k.sign     = (c == CharPlus) || (c == CharMinus);
		k.minus    = (c == CharMinus);
		k.sep      = (c == sep);
		k.zero_ch  = (c == CharZero);
		k.x_ch     = (c == CharLowerX);
		k.hex_ok   = k.digit || ((c >= CharUpperA) && (c <= CharUpperF));
		k.hval     = k.digit ? c[3:0] : 4'(c[3:0] + 4'd9);
		return k;
	endfunction

endpackage

FILE: rtl/hcp_front.sv
// hcp_front: accepts text bytes and classifies them for the parser
// depends on hcp_pkg
module hcp_front
	import hcp_pkg::*;
(
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,        // [7:0] char_byte
	input  logic [7:0]  separator_char,
	input  logic        q_full,
	output logic        q_push,
	output char_class_t q_push_data
);

	// accept whenever the queue has room
	assign s_tready    = !q_full;
	assign q_push      = s_tvalid && !q_full;
	assign q_push_data = classify(s_tdata, separator_char);

endmodule

FILE: rtl/hcp_fifo.sv
// hcp_fifo: short queue of classified bytes between front and back
// depends on hcp_pkg
module hcp_fifo
	import hcp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  char_class_t push_data,
	output logic        full,
	input  logic        pop,
	output char_class_t pop_data,
	output logic        not_empty
);

	char_class_t            entry_q [QDepth];
	logic [QPtrW-1:0]       wr_ptr_q;
	logic [QPtrW-1:0]       rd_ptr_q;
	logic [QCntW-1:0]       count_q;

	assign full      = (count_q == QCntW'(QDepth));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/hcp_back.sv
// hcp_back: token parser state machine and result register
// depends on hcp_pkg
module hcp_back
	import hcp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  char_class_t q_data,
	output logic        q_pop,
	input  logic [31:0] default_color,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     out_result
);

	phase_t      phase_q, phase_d;
	logic        negative_q, negative_d;
	logic [31:0] magnitude_q, magnitude_d;
	logic [31:0] color_accum_q, color_accum_d;
	logic [2:0]  hex_count_q, hex_count_d;
	logic        error_seen_q, error_seen_d;

	logic        out_valid_q;
	result_t     out_q;

	logic        step;
	logic        emit_point;
	logic        emit_line;
	logic        use_accum;
	logic [34:0] mag_next;
	logic        hex_full;
	result_t     res;
	logic [31:0] height_bits;

	// take a byte when the result register is free or being drained
	assign step  = q_not_empty && (!out_valid_q || out_ready);
	assign q_pop = step;

	assign mag_next = ({3'b000, magnitude_q} << 3) + ({3'b000, magnitude_q} << 1)
		+ {31'd0, q_data.dval};
	assign hex_full = (hex_count_q >= HexNeeded);

	// next state
	always_comb begin
		phase_d       = phase_q;
		negative_d    = negative_q;
		magnitude_d   = magnitude_q;
		color_accum_d = color_accum_q;
		hex_count_d   = hex_count_q;
		error_seen_d  = error_seen_q;
		emit_point    = 1'b0;
		emit_line     = 1'b0;
		use_accum     = 1'b0;
		if (q_data.line_end) begin
			emit_line = 1'b1;
			if (!error_seen_q) begin
				case (phase_q)
					PH_DIGITS, PH_ZERO, PH_X: emit_point = 1'b1;
					PH_HEX: begin
						emit_point = 1'b1;
						use_accum  = hex_full;
					end
					default: emit_point = 1'b0;
				endcase
			end
			phase_d       = PH_BETWEEN;
			error_seen_d  = 1'b0;
			negative_d    = 1'b0;
			magnitude_d   = '0;
			color_accum_d = '0;
			hex_count_d   = '0;
		end else if (!error_seen_q) begin
			case (phase_q)
				PH_BETWEEN: begin
					if (!q_data.space) begin
						negative_d    = 1'b0;
						magnitude_d   = '0;
						color_accum_d = '0;
						hex_count_d   = '0;
						if (q_data.sign) begin
							negative_d = q_data.minus;
							phase_d    = PH_DIGITS;
						end else if (q_data.digit) begin
							magnitude_d = {28'd0, q_data.dval};
							phase_d     = PH_DIGITS;
						end else begin
							error_seen_d = 1'b1;
						end
					end
				end
				PH_DIGITS: begin
					if (q_data.digit) begin
						magnitude_d = (mag_next > {3'b000, MagLimit}) ? MagLimit
							: mag_next[31:0];
					end else if (q_data.sep) begin
						phase_d = PH_ZERO;
					end else if (q_data.space) begin
						emit_point = 1'b1;
						phase_d    = PH_BETWEEN;
					end else begin
						error_seen_d = 1'b1;
					end
				end
				PH_ZERO, PH_X: begin
					if ((phase_q == PH_ZERO) && q_data.zero_ch) begin
						phase_d = PH_X;
					end else if ((phase_q == PH_X) && q_data.x_ch) begin
						phase_d = PH_HEX;
					end else begin
						emit_point = 1'b1;
						phase_d    = q_data.space ? PH_BETWEEN : PH_SKIP;
					end
				end
				PH_HEX: begin
					if (q_data.hex_ok) begin
						color_accum_d = {color_accum_q[27:0], q_data.hval};
						if (!hex_full) begin
							hex_count_d = hex_count_q + 3'd1;
						end
					end else begin
						emit_point = 1'b1;
						use_accum  = hex_full;
						phase_d    = q_data.space ? PH_BETWEEN : PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (q_data.space) begin
						phase_d = PH_BETWEEN;
					end
				end
				default: phase_d = PH_BETWEEN;
			endcase
		end
	end

	// result fields
	always_comb begin
		if (negative_q) begin
			height_bits = 32'd0 - magnitude_q;
		end else begin
			height_bits = (magnitude_q > HeightMax) ? HeightMax : magnitude_q;
		end
		res.point_present = emit_point;
		res.height        = emit_point ? height_bits : '0;
		res.color         = !emit_point ? '0 : (use_accum ? color_accum_q : default_color);
		res.error_flag    = emit_line && error_seen_q;
		res.line_done     = emit_line;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_BETWEEN;
			negative_q    <= 1'b0;
			magnitude_q   <= '0;
			color_accum_q <= '0;
			hex_count_q   <= '0;
			error_seen_q  <= 1'b0;
		end else if (step) begin
			phase_q       <= phase_d;
			negative_q    <= negative_d;
			magnitude_q   <= magnitude_d;
			color_accum_q <= color_accum_d;
			hex_count_q   <= hex_count_d;
			error_seen_q  <= error_seen_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= emit_point || emit_line;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_q;

endmodule

FILE: rtl/height_color_token_parser.sv
// height_color_token_parser: top level of the map line token parser
// depends on hcp_pkg, hcp_front, hcp_fifo and hcp_back
//
//   channel  | direction | payload
//   s_*      | in        | tdata[7:0] char_byte
//   m_*      | out       | tdata height, color; tuser point_present, error_flag; tlast line_done
//   cfg_*    | in        | cfg_index register, cfg_data value
//
// one byte per cycle sustained while m_tready drains the result register; an accepted
// byte is written into the queue and parsed as it leaves, and its result, if any,
// is then loaded into the result register that drives m_*.
// arst_n clears the queue, parser state and result valid, and sets the configuration registers to their reset values.
// a stalled m_tready holds the result register; the four-entry queue keeps
// s_tready high until it fills.
module height_color_token_parser
	import hcp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] char_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,    // [31:0] height, [63:32] color
	output logic [1:0]  m_tuser,    // [0] point_present, [1] error_flag
	output logic        m_tlast,    // line_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] default_color_q;
	logic [7:0]  separator_char_q;
	logic        q_full;
	logic        q_push;
	char_class_t q_push_data;
	logic        q_pop;
	char_class_t q_pop_data;
	logic        q_not_empty;
	result_t     result;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_color_q  <= DefaultColorReset;
			separator_char_q <= SeparatorReset;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_DEFAULT_COLOR: default_color_q  <= cfg_data;
				CFG_SEPARATOR:     separator_char_q <= cfg_data[7:0];
				default:           default_color_q  <= default_color_q;
			endcase
		end
	end

	// classifier
	hcp_front u_front (
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.separator_char (separator_char_q),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_push_data    (q_push_data)
	);

	// queue between front and back
	hcp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.not_empty (q_not_empty)
	);

	// parser
	hcp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_data        (q_pop_data),
		.q_pop         (q_pop),
		.default_color (default_color_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_result    (result)
	);

	// output packing
	assign m_tdata = {result.color, result.height};
	assign m_tuser = {result.error_flag, result.point_present};
	assign m_tlast = result.line_done;

endmodule
